@@ hw/rtl/shape_pair_collision_test_unit_assert.svh @@
// assertion macros shared by the rtl files
`ifndef SHAPE_PAIR_COLLISION_TEST_UNIT_ASSERT_SVH
`define SHAPE_PAIR_COLLISION_TEST_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define SPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/spc_pkg.sv @@
package spc_pkg;

	localparam int INDEX_BITS = 10;
	localparam int SIZE_BITS  = 15;
	localparam int POS_BITS   = 16;
	// distances in half-lsb units
	localparam int DIST_BITS  = POS_BITS + 1;
	localparam int SUM_BITS   = SIZE_BITS + 1;
	localparam int SQ_BITS    = 2 * DIST_BITS;
	localparam int FULL_BITS  = SQ_BITS + 2;
	localparam int Q_DEPTH    = 2;
	localparam logic [16:0] SQRT2_Q16 = 17'd92682;

	typedef enum logic [1:0] {
		T_CUBE   = 2'd0,
		T_BALL   = 2'd1,
		T_CYL    = 2'd2,
		T_RING   = 2'd3
	} shape_t;

	typedef enum logic [2:0] {
		K_NONE, K_SPH_SPH, K_SPH_CUBE, K_SPH_CYL, K_CUBE_CUBE, K_CYL_CUBE, K_CYL_CYL
	} kind_t;

	// one classified pair, as it travels through the queue
	typedef struct packed {
		kind_t                  kind;
		logic [INDEX_BITS-1:0]  i0;
		logic [INDEX_BITS-1:0]  i1;
		logic [SIZE_BITS-1:0]   r0;
		logic [SIZE_BITS-1:0]   r1;
		logic [DIST_BITS-1:0]   dx;
		logic [DIST_BITS-1:0]   dy;
		logic [DIST_BITS-1:0]   dz;
	} pair_t;

	typedef struct packed {
		logic hit;
		logic [INDEX_BITS-1:0] i0;
		logic [INDEX_BITS-1:0] i1;
	} res_t;

endpackage

@@ hw/rtl/spc_front.sv @@
module spc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [149:0]         in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output spc_pkg::pair_t       out_pair
);

	logic [spc_pkg::INDEX_BITS-1:0] ia, ib;
	logic [1:0] ta, tb, t0, t1;
	logic [spc_pkg::SIZE_BITS-1:0] sa, sb;
	logic signed [spc_pkg::POS_BITS-1:0] ax, ay, az, bx, by, bz;
	logic swap;
	spc_pkg::pair_t pair;
	logic valid_s1;
	spc_pkg::pair_t pair_s1;

	function automatic logic [spc_pkg::DIST_BITS-1:0] adist(
		input logic signed [spc_pkg::POS_BITS-1:0] a,
		input logic signed [spc_pkg::POS_BITS-1:0] b);
		logic signed [spc_pkg::POS_BITS:0] d;
		logic [spc_pkg::POS_BITS:0] m;
		d = {a[spc_pkg::POS_BITS-1], a} - {b[spc_pkg::POS_BITS-1], b};
		m = d[spc_pkg::POS_BITS] ? -d : d;
		return {m[spc_pkg::POS_BITS-1:0], 1'b0};
	endfunction

	always_comb begin
		ia = in_data[9:0];
		ta = in_data[11:10];
		sa = in_data[26:12];
		ax = in_data[42:27];
		ay = in_data[58:43];
		az = in_data[74:59];
		ib = in_data[84:75];
		tb = in_data[86:85];
		sb = in_data[101:87];
		bx = in_data[117:102];
		by = in_data[133:118];
		bz = in_data[149:134];
		swap = ((tb == spc_pkg::T_RING || tb == spc_pkg::T_BALL) && ta != spc_pkg::T_RING) ||
			(ta == spc_pkg::T_CUBE && tb == spc_pkg::T_CYL);
		t0 = swap ? tb : ta;
		t1 = swap ? ta : tb;
		pair.i0 = swap ? ib : ia;
		pair.i1 = swap ? ia : ib;
		pair.r0 = swap ? sb : sa;
		pair.r1 = swap ? sa : sb;
		pair.dx = adist(ax, bx);
		pair.dy = adist(ay, by);
		pair.dz = adist(az, bz);
		pair.kind = spc_pkg::K_NONE;
		if (t0 == spc_pkg::T_BALL && t1 == spc_pkg::T_BALL) pair.kind = spc_pkg::K_SPH_SPH;
		if (t0 == spc_pkg::T_BALL && t1 == spc_pkg::T_CUBE) pair.kind = spc_pkg::K_SPH_CUBE;
		if (t0 == spc_pkg::T_BALL && t1 == spc_pkg::T_CYL) pair.kind = spc_pkg::K_SPH_CYL;
		if (t0 == spc_pkg::T_CUBE && t1 == spc_pkg::T_CUBE) pair.kind = spc_pkg::K_CUBE_CUBE;
		if (t0 == spc_pkg::T_CYL && t1 == spc_pkg::T_CUBE) pair.kind = spc_pkg::K_CYL_CUBE;
		if (t0 == spc_pkg::T_CYL && t1 == spc_pkg::T_CYL) pair.kind = spc_pkg::K_CYL_CYL;
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_pair  = pair_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pair_s1 <= pair;
		end
	end

endmodule

@@ hw/rtl/spc_queue.sv @@
module spc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  spc_pkg::pair_t wr_pair,
	output logic           rd_valid,
	input  logic           rd_ready,
	output spc_pkg::pair_t rd_pair
);

	spc_pkg::pair_t mem_q [spc_pkg::Q_DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'(spc_pkg::Q_DEPTH);
	assign rd_valid = cnt_q != 2'd0;
	assign rd_pair  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_pair;
		end
	end

	`include "shape_pair_collision_test_unit_assert.svh"
	`SPC_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 2'(spc_pkg::Q_DEPTH))
	`SPC_ASSERT_NEXT(a_full_grow, clk, arst_n, wr && !rd, cnt_q == $past(cnt_q) + 2'd1)
	`SPC_ASSERT_IMP(a_ptr_cnt, clk, arst_n, cnt_q == 2'd0, wp_q == rp_q)

endmodule

@@ hw/rtl/spc_back.sv @@
module spc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  spc_pkg::pair_t in_pair,
	output logic           out_valid,
	input  logic           out_ready,
	output spc_pkg::res_t  out_res
);

	localparam int D = spc_pkg::DIST_BITS;
	localparam int SB = spc_pkg::SUM_BITS;
	localparam int BB = spc_pkg::SUM_BITS + 1;
	localparam int QB = spc_pkg::SQ_BITS;
	localparam int FB = spc_pkg::FULL_BITS;

	// stage 1: squares and simple compares
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;
	spc_pkg::pair_t p_s1;
	logic [SB-1:0] s_c, dd_c;
	logic [SB-1:0] s_s1, dd_s1;
	logic [BB-1:0] b_s1;
	logic [QB-1:0] dx2_s1, dy2_s1, dz2_s1, cx2_s1, cy2_s1, cz2_s1, s2_s1, r12_s1, r02_s1, b2;
	logic [D-1:0] cx, cy, cz;
	logic [33:0] bprod;

	// stage 2: sums and final compares
	logic hit_c, box, corner;
	logic [FB-1:0] full, flat, csum, lim;
	logic [spc_pkg::INDEX_BITS-1:0] i0_s3, i1_s3;
	logic hit_s3;

	always_comb begin
		s_c  = SB'(in_pair.r0) + SB'(in_pair.r1);
		dd_c = in_pair.r1 > in_pair.r0 ? SB'(in_pair.r1 - in_pair.r0)
			: SB'(in_pair.r0 - in_pair.r1);
		cx = in_pair.dx - D'(in_pair.r1);
		cy = in_pair.dy - D'(in_pair.r1);
		cz = in_pair.dz - D'(in_pair.r1);
		bprod = 34'(spc_pkg::SQRT2_Q16) * 34'(in_pair.r1) + 34'd32768;
	end

	assign adv3 = !v_s3 || out_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			p_s1   <= in_pair;
			s_s1   <= s_c;
			dd_s1  <= dd_c;
			b_s1   <= BB'(in_pair.r0) + BB'(bprod[33:16]);
			dx2_s1 <= in_pair.dx * in_pair.dx;
			dy2_s1 <= in_pair.dy * in_pair.dy;
			dz2_s1 <= in_pair.dz * in_pair.dz;
			cx2_s1 <= cx * cx;
			cy2_s1 <= cy * cy;
			cz2_s1 <= cz * cz;
			s2_s1  <= QB'(s_c) * QB'(s_c);
			r12_s1 <= QB'(in_pair.r1) * QB'(in_pair.r1);
			r02_s1 <= QB'(in_pair.r0) * QB'(in_pair.r0);
		end
	end

	// second square for the sphere-cylinder bound
	logic [QB-1:0] b2_s2;
	spc_pkg::pair_t p_s2;
	logic [SB-1:0] s_s2, dd_s2;
	logic [QB-1:0] dx2_s2, dy2_s2, dz2_s2, cx2_s2, cy2_s2, cz2_s2, s2_s2, r12_s2, r02_s2;
	assign b2 = QB'(b_s1) * QB'(b_s1);

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			p_s2 <= p_s1; s_s2 <= s_s1; dd_s2 <= dd_s1; b2_s2 <= b2;
			dx2_s2 <= dx2_s1; dy2_s2 <= dy2_s1; dz2_s2 <= dz2_s1;
			cx2_s2 <= cx2_s1; cy2_s2 <= cy2_s1; cz2_s2 <= cz2_s1;
			s2_s2 <= s2_s1; r12_s2 <= r12_s1; r02_s2 <= r02_s1;
		end
	end

	always_comb begin
		full = FB'(dx2_s2) + FB'(dy2_s2) + FB'(dz2_s2);
		flat = FB'(dx2_s2) + FB'(dz2_s2);
		csum = FB'(cx2_s2) + FB'(cy2_s2) + FB'(cz2_s2);
		lim  = p_s2.kind == spc_pkg::K_CYL_CUBE ? FB'(r02_s2) << 1 : FB'(r02_s2);
		box  = p_s2.dx <= D'(s_s2) && p_s2.dy <= D'(s_s2) && p_s2.dz <= D'(s_s2);
		if (p_s2.dx >= D'(s_s2) || p_s2.dy >= D'(s_s2) || p_s2.dz >= D'(s_s2))
			corner = 1'b0;
		else if (p_s2.dx < D'(dd_s2) && p_s2.dy < D'(dd_s2) && p_s2.dz < D'(dd_s2))
			corner = 1'b0;
		else if (p_s2.dx < D'(p_s2.r1) || p_s2.dy < D'(p_s2.r1) || p_s2.dz < D'(p_s2.r1))
			corner = 1'b1;
		else
			corner = csum < lim;
		unique case (p_s2.kind)
			spc_pkg::K_SPH_SPH: hit_c = full <= FB'(s2_s2) && full >= FB'(r12_s2);
			spc_pkg::K_SPH_CUBE, spc_pkg::K_CYL_CUBE: hit_c = corner;
			spc_pkg::K_SPH_CYL: hit_c = (flat <= FB'(s2_s2) && p_s2.dy <= D'(p_s2.r1))
				|| full <= FB'(b2_s2);
			spc_pkg::K_CUBE_CUBE: hit_c = p_s2.dx >= D'(dd_s2) || p_s2.dy >= D'(dd_s2)
				|| p_s2.dz >= D'(dd_s2);
			spc_pkg::K_CYL_CYL: begin
				if (flat > FB'(s2_s2) || p_s2.dy >= D'(s_s2)) hit_c = 1'b0;
				else if (p_s2.dy < D'(p_s2.r1)) hit_c = 1'b1;
				else hit_c = full <= (FB'(s2_s2) << 1);
			end
			default: hit_c = 1'b0;
		endcase
		hit_c = hit_c && box;
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			hit_s3 <= hit_c;
			i0_s3  <= p_s2.i0;
			i1_s3  <= p_s2.i1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	assign out_valid  = v_s3;
	assign out_res.hit = hit_s3;
	assign out_res.i0  = i0_s3;
	assign out_res.i1  = i1_s3;

	`include "shape_pair_collision_test_unit_assert.svh"
	`SPC_ASSERT_NEXT(a_hold, clk, arst_n, v_s3 && !out_ready, v_s3 && $stable(i0_s3))
	`SPC_ASSERT_IMP(a_ready, clk, arst_n, !v_s1, in_ready)
	`SPC_ASSERT_NEXT(a_move, clk, arst_n, v_s2 && adv3, v_s3)

endmodule

@@ hw/rtl/shape_pair_collision_test_unit.sv @@
// from input beat to result beat: front stage, queue, three back stages
// throughput: one pair per cycle, sustained under no back pressure
// the two-entry queue lets front and back stall on their own
// reset: arst_n clears all valid flags and queue pointers; payloads are not reset
module shape_pair_collision_test_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// index_a, type_a, size_a, pos_ax, pos_ay, pos_az, index_b, type_b, size_b,
	// pos_bx, pos_by, pos_bz, then 2 zero bits
	input  logic [151:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit, first_index, second_index, then 3 zero bits
	output logic [23:0]  m_tdata
);

	// front: canonical ordering, axis distances, pair kind
	logic f_valid, f_ready, b_valid, b_ready;
	spc_pkg::pair_t f_pair, b_pair;
	spc_pkg::res_t res;

	spc_front u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_data(s_tdata[149:0]),
		.out_valid(f_valid), .out_ready(f_ready), .out_pair(f_pair)
	);

	// queue between classify and test
	spc_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_pair(f_pair),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_pair(b_pair)
	);

	// back: squares, bounds and type-specific tests
	spc_back u_back (
		.clk, .arst_n,
		.in_valid(b_valid), .in_ready(b_ready), .in_pair(b_pair),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
	);

	assign m_tdata = {3'b000, res.i1, res.i0, res.hit};

endmodule

@@ sim/shape_pair_collision_test_unit_tb.sv @@
module shape_pair_collision_test_unit_tb;
	import spc_pkg::*;

	// one candidate pair as it goes on the input bus
	typedef struct {
		logic [INDEX_BITS-1:0] idx_a;
		shape_t                kind_a;
		logic [SIZE_BITS-1:0]  size_a;
		logic [POS_BITS-1:0]   pa [3];
		logic [INDEX_BITS-1:0] idx_b;
		shape_t                kind_b;
		logic [SIZE_BITS-1:0]  size_b;
		logic [POS_BITS-1:0]   pb [3];
	} pair_in_t;

	// directed row: pair plus an optional typed-in verdict
	typedef struct {
		pair_in_t p;
		bit       fixed;
		res_t     want;
	} row_t;

	localparam int LIMIT = 400000;
	localparam int LATENCY = 5;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [151:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;

	res_t verdicts_due [$];
	int   n_err;
	int   cycles = 0;
	int   src_idle_pct;
	int   dst_idle_pct;
	bit   feeding;

	shape_pair_collision_test_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// fields from the lowest bit up, same order as the port comment
	function automatic logic [151:0] pack_pair(pair_in_t p);
		return {2'b0, p.pb[2], p.pb[1], p.pb[0], p.size_b, p.kind_b, p.idx_b,
			p.pa[2], p.pa[1], p.pa[0], p.size_a, p.kind_a, p.idx_a};
	endfunction

	function automatic longint sq(longint v);
		return v * v;
	endfunction

	// cube corner test shared by sphere-cube and cylinder-cube
	function automatic bit corner_hit(longint dx, longint dy, longint dz, longint r1,
			longint s, longint dd, longint lim);
		if (dx >= s || dy >= s || dz >= s) return 1'b0;
		if (dx < dd && dy < dd && dz < dd) return 1'b0;
		if (dx < r1 || dy < r1 || dz < r1) return 1'b1;
		return sq(dx - r1) + sq(dy - r1) + sq(dz - r1) < lim;
	endfunction

	// canonical ordering and type-specific overlap, in half-lsb units
	function automatic res_t collide(pair_in_t p);
		res_t   r;
		bit     swap;
		shape_t t0, t1;
		longint r0, r1, s, dd, full, flat, b;
		longint d [3];
		swap = ((p.kind_b == T_RING || p.kind_b == T_BALL) && p.kind_a != T_RING) ||
			(p.kind_a == T_CUBE && p.kind_b == T_CYL);
		t0 = swap ? p.kind_b : p.kind_a;
		t1 = swap ? p.kind_a : p.kind_b;
		r0 = swap ? p.size_b : p.size_a;
		r1 = swap ? p.size_a : p.size_b;
		r.i0 = swap ? p.idx_b : p.idx_a;
		r.i1 = swap ? p.idx_a : p.idx_b;
		r.hit = 1'b0;
		for (int k = 0; k < 3; k++) begin
			d[k] = longint'($signed(p.pa[k])) - longint'($signed(p.pb[k]));
			if (d[k] < 0) d[k] = -d[k];
			d[k] = 2 * d[k];
		end
		s = r0 + r1;
		dd = r1 > r0 ? r1 - r0 : r0 - r1;
		if (d[0] <= s && d[1] <= s && d[2] <= s) begin
			full = sq(d[0]) + sq(d[1]) + sq(d[2]);
			flat = sq(d[0]) + sq(d[2]);
			case (t0)
				T_BALL: begin
					if (t1 == T_BALL) r.hit = full <= sq(s) && full >= sq(r1);
					else if (t1 == T_CUBE) r.hit = corner_hit(d[0], d[1], d[2], r1, s, dd, sq(r0));
					else if (t1 == T_CYL) begin
						if (flat <= sq(s) && d[1] <= r1) r.hit = 1'b1;
						else begin
							b = r0 + ((longint'(SQRT2_Q16) * r1 + 32768) >>> 16);
							r.hit = full <= sq(b);
						end
					end
				end
				T_CUBE: begin
					if (t1 == T_CUBE) r.hit = d[0] >= dd || d[1] >= dd || d[2] >= dd;
				end
				T_CYL: begin
					if (t1 == T_CUBE)
						r.hit = corner_hit(d[0], d[1], d[2], r1, s, dd, 2 * r0 * r0);
					else if (t1 == T_CYL) begin
						if (flat > sq(s) || d[1] >= s) r.hit = 1'b0;
						else if (d[1] < r1) r.hit = 1'b1;
						else r.hit = full <= 2 * sq(s);
					end
				end
				default: r.hit = 1'b0;
			endcase
		end
		return r;
	endfunction

	function automatic pair_in_t mk(int ia, shape_t ta, int sa, int ax, int ay, int az,
			int ib, shape_t tb, int sb, int bx, int by, int bz);
		pair_in_t p;
		p.idx_a = INDEX_BITS'(ia); p.kind_a = ta; p.size_a = SIZE_BITS'(sa);
		p.pa[0] = POS_BITS'(ax); p.pa[1] = POS_BITS'(ay); p.pa[2] = POS_BITS'(az);
		p.idx_b = INDEX_BITS'(ib); p.kind_b = tb; p.size_b = SIZE_BITS'(sb);
		p.pb[0] = POS_BITS'(bx); p.pb[1] = POS_BITS'(by); p.pb[2] = POS_BITS'(bz);
		return p;
	endfunction

	// random pair: mostly close and similarly sized so the shape tests engage
	function automatic pair_in_t rand_pair();
		pair_in_t p;
		int       span;
		p.idx_a = INDEX_BITS'($urandom); p.idx_b = INDEX_BITS'($urandom);
		p.kind_a = shape_t'($urandom_range(3)); p.kind_b = shape_t'($urandom_range(3));
		if ($urandom_range(9) == 0) begin
			// full-range noise
			p.size_a = SIZE_BITS'($urandom); p.size_b = SIZE_BITS'($urandom);
			for (int k = 0; k < 3; k++) begin
				p.pa[k] = POS_BITS'($urandom); p.pb[k] = POS_BITS'($urandom);
			end
		end else begin
			span = 1 << $urandom_range(14, 4);
			p.size_a = SIZE_BITS'($urandom_range(span - 1));
			p.size_b = SIZE_BITS'($urandom_range(span - 1));
			for (int k = 0; k < 3; k++) begin
				p.pa[k] = POS_BITS'($urandom);
				p.pb[k] = p.pa[k] + POS_BITS'($urandom_range(span - 1)) - POS_BITS'(span / 2);
			end
		end
		return p;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		n_err++;
	endtask

	// one beat; a typed-in verdict is cross-checked against the predictor too
	task automatic send_pair(pair_in_t p, bit fixed, res_t want);
		res_t pred;
		pred = collide(p);
		if (fixed && pred !== want) report_mismatch("table row", int'(pred), int'(want));
		while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pack_pair(p);
		do @(posedge clk); while (!s_tready);
		verdicts_due = {verdicts_due, (fixed ? want : pred)};
	endtask

	// receiver stalls at random while feeding runs, then drains freely
	always @(posedge clk) begin
		if (arst_n) m_tready <= !(feeding && $urandom_range(99) < dst_idle_pct);
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.hit = m_tdata[0];
			got.i0  = m_tdata[10:1];
			got.i1  = m_tdata[20:11];
			if (verdicts_due.size() == 0) report_mismatch("unexpected beat", int'(got), 0);
			else begin
				want = verdicts_due.pop_front();
				if (got.hit !== want.hit)
					report_mismatch("hit", int'(got.hit), int'(want.hit));
				if (got.i0 !== want.i0) report_mismatch("first_index", int'(got.i0), int'(want.i0));
				if (got.i1 !== want.i1)
					report_mismatch("second_index", int'(got.i1), int'(want.i1));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		row_t rows [$];
		row_t r;
		res_t none;
		n_err = 0;
		feeding = 1'b1;
		src_idle_pct = 0;
		dst_idle_pct = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		none = '0;
		// far apart on x: box reject, sphere moved first
		r.p = mk(1, T_CUBE, 256, -32768, 0, 0, 2, T_BALL, 256, 32767, 0, 0);
		r.fixed = 1; r.want = '{hit: 0, i0: 2, i1: 1}; rows = {rows, r};
		// ring with anything never hits, ring goes first
		r.p = mk(1023, T_CUBE, 32767, 0, 0, 0, 0, T_RING, 32767, 0, 0, 0);
		r.fixed = 1; r.want = '{hit: 0, i0: 0, i1: 1023}; rows = {rows, r};
		r.p = mk(5, T_RING, 32767, 0, 0, 0, 6, T_RING, 32767, 0, 0, 0);
		r.fixed = 1; r.want = '{hit: 0, i0: 5, i1: 6}; rows = {rows, r};
		// two spheres swap; concentric equal spheres touch the shell
		r.p = mk(7, T_BALL, 100, 0, 0, 0, 8, T_BALL, 100, 0, 0, 0);
		r.fixed = 0; rows = {rows, r};
		r.p = mk(7, T_BALL, 0, 0, 0, 0, 8, T_BALL, 0, 0, 0, 0);
		r.fixed = 1; r.want = '{hit: 1, i0: 8, i1: 7}; rows = {rows, r};
		// cube given before cylinder: cylinder is moved first
		r.p = mk(9, T_CUBE, 300, 0, 0, 0, 10, T_CYL, 300, 100, 0, 0);
		r.fixed = 0; rows = {rows, r};
		// cube inside cube: containment, no hit
		r.p = mk(11, T_CUBE, 1000, 0, 0, 0, 12, T_CUBE, 100, 10, 10, 10);
		r.fixed = 1; r.want = '{hit: 0, i0: 11, i1: 12}; rows = {rows, r};
		r.p = mk(11, T_CUBE, 200, 0, 0, 0, 12, T_CUBE, 200, 150, 0, 0);
		r.fixed = 1; r.want = '{hit: 1, i0: 11, i1: 12}; rows = {rows, r};
		// sphere near cube corner, sphere against cylinder, cylinder pairs
		r.p = mk(13, T_CUBE, 400, 0, 0, 0, 14, T_BALL, 200, 280, 280, 280);
		r.fixed = 0; rows = {rows, r};
		r.p = mk(15, T_CYL, 400, 0, 0, 0, 16, T_BALL, 200, 250, 250, 50);
		r.fixed = 0; rows = {rows, r};
		r.p = mk(15, T_CYL, 400, 0, 0, 0, 16, T_BALL, 200, 100, 350, 100);
		r.fixed = 0; rows = {rows, r};
		r.p = mk(17, T_CYL, 300, 0, 0, 0, 18, T_CYL, 300, 200, 200, 200);
		r.fixed = 0; rows = {rows, r};
		r.p = mk(17, T_CYL, 300, 0, 0, 0, 18, T_CYL, 300, 100, 50, 100);
		r.fixed = 0; rows = {rows, r};
		r.p = mk(19, T_CYL, 300, 0, 0, 0, 20, T_CUBE, 300, 250, 250, 250);
		r.fixed = 0; rows = {rows, r};
		// extreme positions and sizes, all-ones fields
		r.p = mk(1023, T_CYL, 32767, 32767, 32767, 32767, 1023, T_CYL, 32767,
			-32768, -32768, -32768);
		r.fixed = 0; rows = {rows, r};
		r.p = mk(0, T_BALL, 32767, -1, -1, -1, 1023, T_CUBE, 32767, 0, 0, 0);
		r.fixed = 0; rows = {rows, r};
		r.p = mk(512, T_BALL, 0, 0, 0, 0, 3, T_CYL, 0, 0, 0, 0);
		r.fixed = 0; rows = {rows, r};

		foreach (rows[i]) send_pair(rows[i].p, rows[i].fixed, rows[i].want);

		// random pairs in three pacing phases
		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 58 : 0;
			dst_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 34 : 0;
			repeat (130) send_pair(rand_pair(), 1'b0, none);
		end
		s_tvalid <= 1'b0;

		feeding = 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (LATENCY * 4) @(posedge clk);
		if (n_err == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
